// ===== rtl/core/bmap_pkg.sv =====
package bmap_pkg;

   localparam int SPD_W  = 11;
   localparam int ANG_W  = 15;
   localparam int WB_W   = 18;
   localparam int POS_W  = 20;
   localparam int HEAD_W = 32;
   localparam int CNT_W  = 6;
   localparam int XY_W   = 34;
   localparam int PROD_W = 49;
   localparam int DEN_W  = 53;
   localparam int NUM_W  = 64;
   localparam int QUO_W  = 24;
   localparam int DTH_W  = 25;
   localparam int IDX_W  = 5;

   localparam int DEF_LEAD_POINTS = 10;
   localparam int DEF_CORDIC_ITERATIONS = 16;

   localparam logic [CNT_W-1:0] MAX_RESULTS = 6'd60;
   localparam logic [CNT_W-1:0] BASE_POINTS = 6'd10;

   localparam logic signed [SPD_W-1:0] SPD_MAX = 11'sd512;
   localparam logic signed [SPD_W-1:0] SPD_MIN = -11'sd512;
   localparam logic signed [ANG_W-1:0] ANG_MAX = 15'sd9830;
   localparam logic signed [ANG_W-1:0] ANG_MIN = -15'sd9830;
   localparam logic [WB_W-1:0] WB_MIN   = 18'd6554;
   localparam logic [WB_W-1:0] WB_MAX   = 18'd131072;
   localparam logic [WB_W-1:0] WB_RESET = 18'd19661;

   localparam logic signed [XY_W-1:0] CORDIC_K = 34'sd652032874;
   localparam logic signed [HEAD_W-1:0] PI_Q16      = 32'sd205887;
   localparam logic signed [HEAD_W-1:0] HALF_PI_Q16 = 32'sd102944;
   localparam logic signed [HEAD_W-1:0] TWO_PI_Q16  = 32'sd411775;

   // step = round(c / 163840) = ((|c| + 81920) >> 15) / 5
   localparam logic [XY_W-1:0] STEP_HALF = 34'd81920;
   localparam logic [15:0] RECIP5 = 16'd52429;

   function automatic logic [16:0] atan_q16(input logic [IDX_W-1:0] i);
      logic [16:0] a;
      unique case (i)
         5'd0:  a = 17'd51472;
         5'd1:  a = 17'd30386;
         5'd2:  a = 17'd16055;
         5'd3:  a = 17'd8150;
         5'd4:  a = 17'd4091;
         5'd5:  a = 17'd2047;
         5'd6:  a = 17'd1024;
         5'd7:  a = 17'd512;
         5'd8:  a = 17'd256;
         5'd9:  a = 17'd128;
         5'd10: a = 17'd64;
         5'd11: a = 17'd32;
         5'd12: a = 17'd16;
         5'd13: a = 17'd8;
         5'd14: a = 17'd4;
         5'd15: a = 17'd2;
         5'd16: a = 17'd1;
         default: a = 17'd0;
      endcase
      return a;
   endfunction

   typedef enum logic [3:0] {
      ST_IDLE, ST_TAN_GO, ST_TAN_WAIT, ST_MUL, ST_DEN, ST_DIV_GO, ST_DIV_WAIT,
      ST_STEP_GO, ST_STEP_WAIT, ST_SCALE, ST_RECIP, ST_UPDATE, ST_EMIT, ST_LEAD_OUT
   } ctrl_state_type;

   typedef enum logic [2:0] {
      CP_IDLE, CP_REDUCE, CP_QUAD, CP_ITER, CP_DONE
   } cordic_phase_type;

   typedef struct packed {
      logic             item_load;
      logic             cordic_start;
      logic             cordic_heading;
      logic             mul_en;
      logic             den_en;
      logic             div_start;
      logic             dth_load;
      logic             scale_en;
      logic             recip_en;
      logic             update_en;
      logic             dir_fwd;
      logic             pose_clear;
      logic             lead_wr;
      logic             out_load;
      logic             out_from_lead;
      logic             out_last;
      logic [CNT_W-1:0] idx;
   } dp_cmd_type;

   typedef struct packed {
      logic             cordic_done;
      logic             div_done;
      logic             out_free;
      logic             is_rev;
      logic [CNT_W-1:0] n_points;
   } dp_status_type;

endpackage

// ===== rtl/core/bmap_cordic.sv =====
module bmap_cordic #(
   parameter int ITERS = bmap_pkg::DEF_CORDIC_ITERATIONS
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   input  logic signed [bmap_pkg::HEAD_W-1:0]    angle,
   output logic                                  done,
   output logic signed [bmap_pkg::XY_W-1:0]      cos_out,
   output logic signed [bmap_pkg::XY_W-1:0]      sin_out
);
   import bmap_pkg::*;

   localparam int IT_W = $clog2(ITERS);

   cordic_phase_type phase_ff, phase_in;
   logic signed [HEAD_W-1:0] r_ff, r_in;
   logic signed [XY_W-1:0] x_ff, x_in, y_ff, y_in;
   logic flip_ff, flip_in;
   logic [IT_W-1:0] it_ff, it_in;
   logic signed [XY_W-1:0] xs, ys;
   logic signed [HEAD_W-1:0] at;

   assign xs = x_ff >>> it_ff;
   assign ys = y_ff >>> it_ff;
   assign at = HEAD_W'(signed'({1'b0, atan_q16(IDX_W'(it_ff))}));

   always_comb begin
      phase_in = phase_ff;
      unique case (phase_ff)
         CP_IDLE:   if (start) phase_in = CP_REDUCE;
         CP_REDUCE: if (r_ff <= PI_Q16 && r_ff >= -PI_Q16) phase_in = CP_QUAD;
         CP_QUAD:   phase_in = CP_ITER;
         CP_ITER:   if (it_ff == IT_W'(ITERS - 1)) phase_in = CP_DONE;
         CP_DONE:   phase_in = CP_IDLE;
         default:   phase_in = CP_IDLE;
      endcase
   end

   // results hold while idle until the next start
   always_comb begin
      r_in = r_ff;
      x_in = x_ff;
      y_in = y_ff;
      flip_in = flip_ff;
      it_in = it_ff;
      unique case (phase_ff)
         CP_IDLE: begin
            if (start) begin
               r_in = angle;
               x_in = CORDIC_K;
               y_in = '0;
               flip_in = 1'b0;
               it_in = '0;
            end
         end
         CP_REDUCE: begin
            if (r_ff > PI_Q16) r_in = r_ff - TWO_PI_Q16;
            else if (r_ff < -PI_Q16) r_in = r_ff + TWO_PI_Q16;
         end
         CP_QUAD: begin
            if (r_ff > HALF_PI_Q16) begin
               r_in = r_ff - PI_Q16;
               flip_in = 1'b1;
            end else if (r_ff < -HALF_PI_Q16) begin
               r_in = r_ff + PI_Q16;
               flip_in = 1'b1;
            end
         end
         CP_ITER: begin
            if (r_ff >= 0) begin
               x_in = x_ff - ys;
               y_in = y_ff + xs;
               r_in = r_ff - at;
            end else begin
               x_in = x_ff + ys;
               y_in = y_ff - xs;
               r_in = r_ff + at;
            end
            it_in = it_ff + 1'b1;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) phase_ff <= CP_IDLE;
      else phase_ff <= phase_in;
      r_ff <= r_in;
      x_ff <= x_in;
      y_ff <= y_in;
      flip_ff <= flip_in;
      it_ff <= it_in;
   end

   assign done = (phase_ff == CP_DONE);
   assign cos_out = flip_ff ? -x_ff : x_ff;
   assign sin_out = flip_ff ? -y_ff : y_ff;
endmodule

// ===== rtl/core/bmap_div.sv =====
module bmap_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [bmap_pkg::NUM_W-1:0]    num,
   input  logic [bmap_pkg::DEN_W-1:0]    den,
   output logic                          done,
   output logic [bmap_pkg::QUO_W-1:0]    quo
);
   import bmap_pkg::*;

   localparam int DSH_W = DEN_W + QUO_W;
   localparam int K_W = $clog2(QUO_W);

   logic [NUM_W-1:0] rem_ff, rem_in;
   logic [DSH_W-1:0] dsh_ff, dsh_in;
   logic [QUO_W-1:0] quo_ff, quo_in;
   logic [K_W-1:0] k_ff, k_in;
   logic busy_ff, busy_in, done_ff, done_in;
   logic ge;

   // restoring long division, one quotient bit per cycle
   assign ge = ({(DSH_W - NUM_W)'(0), rem_ff} >= dsh_ff);

   always_comb begin
      rem_in = rem_ff;
      dsh_in = dsh_ff;
      quo_in = quo_ff;
      k_in = k_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in = num;
         dsh_in = {den, QUO_W'(0)} >> 1;
         quo_in = '0;
         k_in = K_W'(QUO_W - 1);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (ge) rem_in = rem_ff - dsh_ff[NUM_W-1:0];
         quo_in = {quo_ff[QUO_W-2:0], ge};
         dsh_in = dsh_ff >> 1;
         k_in = k_ff - 1'b1;
         if (k_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      rem_ff <= rem_in;
      dsh_ff <= dsh_in;
      quo_ff <= quo_in;
      k_ff <= k_in;
   end

   assign done = done_ff;
   assign quo = quo_ff;
endmodule

// ===== rtl/core/bmap_datapath.sv =====
module bmap_datapath #(
   parameter int LEAD_POINTS = bmap_pkg::DEF_LEAD_POINTS,
   parameter int CORDIC_ITERATIONS = bmap_pkg::DEF_CORDIC_ITERATIONS
) (
   input  logic                        clock,
   input  logic                        reset,
   input  bmap_pkg::dp_cmd_type        cmd,
   output bmap_pkg::dp_status_type     status,
   input  logic [31:0]                 req_tdata,
   input  logic                        csr_wen,
   input  logic [bmap_pkg::WB_W-1:0]   csr_wdata,
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [39:0]                 rsp_tdata,
   output logic                        rsp_tlast
);
   import bmap_pkg::*;

   localparam int LIW = (LEAD_POINTS > 1) ? $clog2(LEAD_POINTS) : 1;

   logic [WB_W-1:0] wb_ff, wb_sat;
   logic signed [SPD_W-1:0] spd_raw, spd_sat;
   logic signed [ANG_W-1:0] ang_raw, ang_sat, ang_ff;
   logic [SPD_W-1:0] mag;
   logic [15:0] mag20;
   logic rev_ff;
   logic [CNT_W-1:0] n_ff;

   logic signed [HEAD_W-1:0] cordic_ang;
   logic cordic_done;
   logic signed [XY_W-1:0] c_w, s_w;

   logic [PROD_W-1:0] prod_ff;
   logic [DEN_W-1:0] den_ff, den_in;
   logic [NUM_W-1:0] num_ff, num_in;
   logic s_neg_ff;
   logic [XY_W-1:0] s_abs;
   logic div_done;
   logic [QUO_W-1:0] quo;
   logic signed [DTH_W-1:0] dth_ff;

   logic [XY_W-1:0] cx_abs, sy_abs, cx_sum, sy_sum;
   logic [16:0] vx_ff, vy_ff;
   logic negx_ff, negy_ff, stx_neg_ff, sty_neg_ff;
   logic [32:0] px, py;
   logic [14:0] qx_ff, qy_ff;
   logic signed [POS_W-1:0] stepx, stepy;

   logic signed [HEAD_W-1:0] heading_ff, heading_in;
   logic signed [POS_W-1:0] pos_x_ff, pos_x_in, pos_y_ff, pos_y_in;
   logic [2*POS_W-1:0] lead_ff [LEAD_POINTS];

   logic out_valid_ff;
   logic [2*POS_W-1:0] out_data_ff;
   logic out_last_ff;

   always_ff @(posedge clock) begin
      if (reset) wb_ff <= WB_RESET;
      else if (csr_wen) wb_ff <= csr_wdata;
   end

   assign wb_sat = (wb_ff < WB_MIN) ? WB_MIN : ((wb_ff > WB_MAX) ? WB_MAX : wb_ff);

   assign spd_raw = req_tdata[SPD_W-1:0];
   assign ang_raw = req_tdata[SPD_W+ANG_W-1:SPD_W];
   assign spd_sat = (spd_raw > SPD_MAX) ? SPD_MAX : ((spd_raw < SPD_MIN) ? SPD_MIN : spd_raw);
   assign ang_sat = (ang_raw > ANG_MAX) ? ANG_MAX : ((ang_raw < ANG_MIN) ? ANG_MIN : ang_raw);
   assign mag = spd_sat[SPD_W-1] ? SPD_W'(-spd_sat) : SPD_W'(spd_sat);
   // 20*mag = 16*mag + 4*mag
   assign mag20 = ({5'd0, mag} << 4) + ({5'd0, mag} << 2);

   always_ff @(posedge clock) begin
      if (cmd.item_load) begin
         ang_ff <= ang_sat;
         rev_ff <= spd_sat[SPD_W-1];
         n_ff <= BASE_POINTS + CNT_W'(mag20[15:8]);
      end
   end

   assign cordic_ang = cmd.cordic_heading ? heading_ff
                                          : HEAD_W'({{(HEAD_W-ANG_W-2){ang_ff[ANG_W-1]}},
                                                     ang_ff, 2'b00});

   bmap_cordic #(.ITERS(CORDIC_ITERATIONS)) u_cordic (
      .clock   (clock),
      .reset   (reset),
      .start   (cmd.cordic_start),
      .angle   (cordic_ang),
      .done    (cordic_done),
      .cos_out (c_w),
      .sin_out (s_w)
   );

   // heading increment = round(s * 2^32 / (10 * c * wb)); c is positive here
   assign s_abs = s_w[XY_W-1] ? XY_W'(-s_w) : XY_W'(s_w);
   assign den_in = ({4'd0, prod_ff} << 3) + ({4'd0, prod_ff} << 1);
   assign num_in = {s_abs[31:0], 32'd0} + NUM_W'(den_in >> 1);

   always_ff @(posedge clock) begin
      if (cmd.mul_en) begin
         prod_ff <= PROD_W'(c_w[30:0]) * PROD_W'(wb_sat);
         s_neg_ff <= s_w[XY_W-1];
      end
      if (cmd.den_en) begin
         den_ff <= den_in;
         num_ff <= num_in;
      end
      if (cmd.dth_load)
         dth_ff <= s_neg_ff ? -DTH_W'(signed'({1'b0, quo})) : DTH_W'(signed'({1'b0, quo}));
   end

   bmap_div u_div (
      .clock (clock),
      .reset (reset),
      .start (cmd.div_start),
      .num   (num_ff),
      .den   (den_ff),
      .done  (div_done),
      .quo   (quo)
   );

   assign cx_abs = c_w[XY_W-1] ? XY_W'(-c_w) : XY_W'(c_w);
   assign sy_abs = s_w[XY_W-1] ? XY_W'(-s_w) : XY_W'(s_w);
   assign cx_sum = cx_abs + STEP_HALF;
   assign sy_sum = sy_abs + STEP_HALF;
   assign px = vx_ff * RECIP5;
   assign py = vy_ff * RECIP5;
   assign stepx = stx_neg_ff ? -POS_W'(signed'({1'b0, qx_ff})) : POS_W'(signed'({1'b0, qx_ff}));
   assign stepy = sty_neg_ff ? -POS_W'(signed'({1'b0, qy_ff})) : POS_W'(signed'({1'b0, qy_ff}));

   always_ff @(posedge clock) begin
      if (cmd.scale_en) begin
         vx_ff <= cx_sum[31:15];
         vy_ff <= sy_sum[31:15];
         negx_ff <= c_w[XY_W-1];
         negy_ff <= s_w[XY_W-1];
      end
      if (cmd.recip_en) begin
         qx_ff <= px[32:18];
         qy_ff <= py[32:18];
         stx_neg_ff <= negx_ff;
         sty_neg_ff <= negy_ff;
      end
   end

   assign pos_x_in = cmd.dir_fwd ? pos_x_ff + stepx : pos_x_ff - stepx;
   assign pos_y_in = cmd.dir_fwd ? pos_y_ff + stepy : pos_y_ff - stepy;
   assign heading_in = cmd.dir_fwd ? heading_ff + HEAD_W'(dth_ff) : heading_ff - HEAD_W'(dth_ff);

   always_ff @(posedge clock) begin
      if (reset || cmd.pose_clear) begin
         heading_ff <= '0;
         pos_x_ff <= '0;
         pos_y_ff <= '0;
      end else if (cmd.update_en) begin
         heading_ff <= heading_in;
         pos_x_ff <= pos_x_in;
         pos_y_ff <= pos_y_in;
      end
      if (cmd.lead_wr) lead_ff[cmd.idx[LIW-1:0]] <= {pos_y_in, pos_x_in};
   end

   always_ff @(posedge clock) begin
      if (reset) out_valid_ff <= 1'b0;
      else if (cmd.out_load) out_valid_ff <= 1'b1;
      else if (rsp_tready) out_valid_ff <= 1'b0;
      if (cmd.out_load) begin
         out_data_ff <= cmd.out_from_lead ? lead_ff[cmd.idx[LIW-1:0]] : {pos_y_ff, pos_x_ff};
         out_last_ff <= cmd.out_last;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata = out_data_ff;
   assign rsp_tlast = out_last_ff;

   assign status.cordic_done = cordic_done;
   assign status.div_done = div_done;
   assign status.out_free = !out_valid_ff || rsp_tready;
   assign status.is_rev = rev_ff;
   assign status.n_points = n_ff;
endmodule

// ===== rtl/core/bmap_ctrl.sv =====
module bmap_ctrl #(
   parameter int LEAD_POINTS = bmap_pkg::DEF_LEAD_POINTS
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  bmap_pkg::dp_status_type   status,
   output bmap_pkg::dp_cmd_type      cmd
);
   import bmap_pkg::*;

   ctrl_state_type state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in, emit_ff, emit_in;
   logic lead_ff, lead_in;
   logic main_last, cap_hit;

   assign cap_hit = (emit_ff == MAX_RESULTS - 1'b1);
   assign main_last = (cnt_ff == status.n_points - 1'b1) || cap_hit;

   always_comb begin
      state_in = state_ff;
      cnt_in = cnt_ff;
      emit_in = emit_ff;
      lead_in = lead_ff;
      unique case (state_ff)
         ST_IDLE:      if (req_tvalid) state_in = ST_TAN_GO;
         ST_TAN_GO:    state_in = ST_TAN_WAIT;
         ST_TAN_WAIT:  if (status.cordic_done) state_in = ST_MUL;
         ST_MUL:       state_in = ST_DEN;
         ST_DEN:       state_in = ST_DIV_GO;
         ST_DIV_GO:    state_in = ST_DIV_WAIT;
         ST_DIV_WAIT: begin
            if (status.div_done) begin
               state_in = ST_STEP_GO;
               cnt_in = '0;
               emit_in = '0;
               lead_in = status.is_rev;
            end
         end
         ST_STEP_GO:   state_in = ST_STEP_WAIT;
         ST_STEP_WAIT: if (status.cordic_done) state_in = ST_SCALE;
         ST_SCALE:     state_in = ST_RECIP;
         ST_RECIP:     state_in = ST_UPDATE;
         ST_UPDATE: begin
            if (!lead_ff) state_in = ST_EMIT;
            else if (cnt_ff == CNT_W'(LEAD_POINTS - 1)) state_in = ST_LEAD_OUT;
            else begin
               cnt_in = cnt_ff + 1'b1;
               state_in = ST_STEP_GO;
            end
         end
         ST_EMIT: begin
            if (status.out_free) begin
               emit_in = emit_ff + 1'b1;
               cnt_in = cnt_ff + 1'b1;
               state_in = main_last ? ST_IDLE : ST_STEP_GO;
            end
         end
         ST_LEAD_OUT: begin
            if (status.out_free) begin
               emit_in = emit_ff + 1'b1;
               if (cap_hit) state_in = ST_IDLE;
               else if (cnt_ff == '0) begin
                  lead_in = 1'b0;
                  state_in = ST_STEP_GO;
               end else cnt_in = cnt_ff - 1'b1;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      cmd.idx = cnt_ff;
      cmd.dir_fwd = lead_ff || !status.is_rev;
      cmd.cordic_heading = 1'b1;
      unique case (state_ff)
         ST_IDLE:     cmd.item_load = req_tvalid;
         ST_TAN_GO: begin
            cmd.cordic_start = 1'b1;
            cmd.cordic_heading = 1'b0;
         end
         ST_MUL:      cmd.mul_en = 1'b1;
         ST_DEN:      cmd.den_en = 1'b1;
         ST_DIV_GO:   cmd.div_start = 1'b1;
         ST_DIV_WAIT: begin
            cmd.dth_load = status.div_done;
            cmd.pose_clear = status.div_done;
         end
         ST_STEP_GO:  cmd.cordic_start = 1'b1;
         ST_SCALE:    cmd.scale_en = 1'b1;
         ST_RECIP:    cmd.recip_en = 1'b1;
         ST_UPDATE: begin
            cmd.update_en = 1'b1;
            cmd.lead_wr = lead_ff;
         end
         ST_EMIT: begin
            cmd.out_load = status.out_free;
            cmd.out_last = main_last;
         end
         ST_LEAD_OUT: begin
            cmd.out_load = status.out_free;
            cmd.out_from_lead = 1'b1;
            cmd.out_last = cap_hit;
            cmd.pose_clear = status.out_free && !cap_hit && (cnt_ff == '0);
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff <= '0;
         emit_ff <= '0;
         lead_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff <= cnt_in;
         emit_ff <= emit_in;
         lead_ff <= lead_in;
      end
   end

   assign req_tready = (state_ff == ST_IDLE);
endmodule

// ===== rtl/core/bicycle_model_arc_points_unit.sv =====
// Kinematic bicycle path predictor. Each command word (speed, steering angle) yields a
// run of path points from the origin, 0.1 m apart, with tlast on the final point; reverse
// commands first send LEAD_POINTS forward points nearest-last, then the backward path.
// One command at a time: after the word is taken, setup runs one CORDIC pass for tan
// and the divider for the heading increment; then each point is paced by a pass of
// the shared iterative CORDIC, angle reduction included. A reverse run first computes
// each lead point to fill the buffer, then sends them from the buffer. The output
// register lets the last point wait while the next command is taken. Wheelbase is
// written through csr_wen/csr_wdata.
module bicycle_model_arc_points_unit #(
   parameter int LEAD_POINTS = bmap_pkg::DEF_LEAD_POINTS,
   parameter int CORDIC_ITERATIONS = bmap_pkg::DEF_CORDIC_ITERATIONS
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [31:0]                 req_tdata,  // speed[10:0], steer_angle[25:11]
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [39:0]                 rsp_tdata,  // point_x[19:0], point_y[39:20]
   output logic                        rsp_tlast,
   input  logic                        csr_wen,
   input  logic [bmap_pkg::WB_W-1:0]   csr_wdata
);
   import bmap_pkg::*;

   dp_cmd_type cmd;
   dp_status_type status;

   bmap_ctrl #(.LEAD_POINTS(LEAD_POINTS)) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   bmap_datapath #(
      .LEAD_POINTS       (LEAD_POINTS),
      .CORDIC_ITERATIONS (CORDIC_ITERATIONS)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .req_tdata  (req_tdata),
      .csr_wen    (csr_wen),
      .csr_wdata  (csr_wdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );
endmodule
